// ===== hw/rtl/rsi_pkg.sv =====
// shared types, widths and codes of the relative strength index block
`default_nettype none

package rsi_pkg;

	// field and arithmetic widths
	localparam int PRICE_W   = 32;
	localparam int PCT_W     = 7;
	localparam int FRAC_W    = 16;
	localparam int DIFF100_W = PRICE_W + PCT_W;
	localparam int TERM_W    = DIFF100_W + FRAC_W;
	localparam int INDEX_W   = 23;
	localparam int STATUS_W  = 2;
	localparam int WL_W      = 4;

	// register port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

	// constants of the index arithmetic
	localparam logic [WL_W-1:0]    WL_RESET   = 4'd14;
	localparam logic [WL_W-1:0]    WL_MIN     = 4'd2;
	localparam logic [PCT_W-1:0]   PERCENT    = 7'd100;
	localparam logic [INDEX_W-1:0] FULL_SCALE = 23'd6553600;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_FEW   = 2'd0,
		ST_VALID = 2'd1,
		ST_FLAT  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_TERM,
		S_TDIV,
		S_FIN,
		S_FDIV,
		S_EMIT
	} state_t;

	// price history commands
	typedef struct packed {
		logic push;
		logic load;
		logic advance;
	} hist_cmd_t;

	// divider command and status
	typedef struct packed {
		logic start;
		logic final_pass;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsi_if.sv =====
// valid/ready channel interfaces for prices and index results
`default_nettype none

interface rsi_in_if;
	logic                        valid;
	logic                        ready;
	logic [rsi_pkg::PRICE_W-1:0] close_price;

	modport source (output valid, output close_price, input ready);
	modport sink (input valid, input close_price, output ready);
endinterface

interface rsi_out_if;
	logic                         valid;
	logic                         ready;
	logic [rsi_pkg::INDEX_W-1:0]  index_value;
	logic [rsi_pkg::STATUS_W-1:0] result_status;

	modport source (output valid, output index_value, output result_status, input ready);
	modport sink (input valid, input index_value, input result_status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/relative_strength_index_top.sv =====
// Relative strength index over the newest window_length closing prices. One
// price is taken per transaction and one result comes back for each. The
// block works on one price at a time: price_ch.ready is low from acceptance
// until the result has been handed to the output register. Each pair of
// consecutive prices takes one percent-change division plus setup and
// accumulate, and the final ratio one more division, all on the
// one-bit-per-cycle restoring divider that every division shares. A price
// with no price movement skips the final ratio, and one that leaves too few
// samples skips every division. A result still waiting in the output
// register holds the block in its emit state until the register frees.
// window_length sits at byte address 0 and should only be written while no
// price is in flight.
`default_nettype none

module relative_strength_index_top #(
	parameter int WINDOW_DEPTH = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rsi_in_if.sink                     price_ch,
	rsi_out_if.source                  result_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsi_pkg::ADDR_W-1:0] paddr,
	input  logic [rsi_pkg::DATA_W-1:0] pwdata,
	output logic [rsi_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rsi_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = TERM_W + $clog2(WINDOW_DEPTH);
	localparam int NUM_W = SUM_W + PCT_W + FRAC_W;

	state_t               state_q, state_d;
	logic [WL_W-1:0]      wl_q;
	logic [WL_W-1:0]      pairs_q;
	logic [SUM_W-1:0]     gain_q, loss_q;
	logic [INDEX_W-1:0]   res_index_q, out_index_q;
	status_t              res_status_q, out_status_q;
	logic                 out_valid_q;

	hist_cmd_t            hist_cmd;
	div_cmd_t             div_cmd;
	div_stat_t            div_stat;
	logic [NUM_W-1:0]     div_num;
	logic [SUM_W-1:0]     div_den;
	logic [TERM_W-1:0]    quo;
	logic [PRICE_W-1:0]   cur, prev, diff;
	logic [CNT_W-1:0]     held;
	logic [WL_W-1:0]      n_eff;
	logic                 few;
	logic [DIFF100_W-1:0] diff100;
	logic [SUM_W+PCT_W-1:0] gain100;
	logic                 slot_free;
	logic                 cfg_write;

	rsi_hist #(
		.DEPTH (WINDOW_DEPTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hist_cmd),
		.price  (price_ch.close_price),
		.cur    (cur),
		.prev   (prev),
		.held   (held)
	);

	rsi_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W),
		.QUO_W (TERM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (quo)
	);

	// window size and fill check
	always_comb begin
		n_eff = (wl_q < WL_MIN) ? WL_MIN : wl_q;
		few   = (32'(n_eff) > 32'(WINDOW_DEPTH)) || (32'(held) < 32'(n_eff));
	end

	// divider operands: percent change of one pair, or the final ratio
	always_comb begin
		diff    = (cur >= prev) ? (cur - prev) : (prev - cur);
		diff100 = DIFF100_W'(diff) * DIFF100_W'(PERCENT);
		gain100 = (SUM_W+PCT_W)'(gain_q) * (SUM_W+PCT_W)'(PERCENT);
		if (state_q == S_FIN) begin
			div_num = {gain100, {FRAC_W{1'b0}}};
			div_den = gain_q + loss_q;
		end else begin
			div_num = {diff100, {(NUM_W-DIFF100_W){1'b0}}};
			div_den = SUM_W'(prev);
		end
	end

	assign slot_free = !out_valid_q || result_ch.ready;

	// sequencer next state and commands
	always_comb begin
		state_d        = state_q;
		hist_cmd       = '0;
		div_cmd        = '0;
		price_ch.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (price_ch.valid) begin
					hist_cmd.push = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (few) begin
					state_d = S_EMIT;
				end else begin
					hist_cmd.load = 1'b1;
					state_d       = S_TERM;
				end
			end
			S_TERM: begin
				div_cmd.start = 1'b1;
				state_d       = S_TDIV;
			end
			S_TDIV: begin
				if (div_stat.done) begin
					hist_cmd.advance = 1'b1;
					state_d          = (pairs_q == WL_W'(1)) ? S_FIN : S_TERM;
				end
			end
			S_FIN: begin
				if (gain_q == '0 && loss_q == '0) begin
					state_d = S_EMIT;
				end else begin
					div_cmd.start      = 1'b1;
					div_cmd.final_pass = 1'b1;
					state_d            = S_FDIV;
				end
			end
			S_FDIV: begin
				if (div_stat.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// gain and loss sums, pair count and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHECK: begin
				pairs_q <= n_eff - WL_W'(1);
				gain_q  <= '0;
				loss_q  <= '0;
				if (few) begin
					res_index_q  <= '0;
					res_status_q <= ST_FEW;
				end
			end
			S_TDIV: begin
				if (div_stat.done) begin
					pairs_q <= pairs_q - WL_W'(1);
					if (cur > prev) begin
						gain_q <= gain_q + SUM_W'(quo);
					end else begin
						loss_q <= loss_q + SUM_W'(quo);
					end
				end
			end
			S_FIN: begin
				if (gain_q == '0 && loss_q == '0) begin
					res_index_q  <= '0;
					res_status_q <= ST_FLAT;
				end
			end
			S_FDIV: begin
				if (div_stat.done) begin
					res_index_q  <= quo[INDEX_W-1:0];
					res_status_q <= ST_VALID;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					out_index_q  <= res_index_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.index_value   = out_index_q;
	assign result_ch.result_status = out_status_q;

	// register port
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH) ? DATA_W'(wl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_RESET;
		end else if (cfg_write && paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
			wl_q <= pwdata[WL_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	// only a valid index carries a nonzero value
	a_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.result_status != ST_VALID)
			|-> result_ch.index_value == '0)
		else $error("index nonzero on a result that is not valid");

	// a valid index never exceeds one hundred
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.result_status == ST_VALID)
			|-> result_ch.index_value <= FULL_SCALE)
		else $error("index above full scale");

	// waiting on the divider only while it runs or reports
	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TDIV || state_q == S_FDIV) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// a pair is always left while a term divides
	a_pairs_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TDIV) |-> pairs_q != '0)
		else $error("pair count exhausted during a term");

	// one price at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(price_ch.valid && price_ch.ready) |=> !price_ch.ready)
		else $error("second price taken while one is in flight");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_hist.sv =====
// price history shift line, sample count and working copy for the pair walk
`default_nettype none

module rsi_hist #(
	parameter int DEPTH = 14,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsi_pkg::hist_cmd_t          cmd,
	input  logic [rsi_pkg::PRICE_W-1:0] price,
	output logic [rsi_pkg::PRICE_W-1:0] cur,
	output logic [rsi_pkg::PRICE_W-1:0] prev,
	output logic [CNT_W-1:0]            held
);
	import rsi_pkg::*;

	logic [PRICE_W-1:0] prices_q [DEPTH];
	logic [PRICE_W-1:0] work_q [DEPTH];
	logic [CNT_W-1:0]   held_q;

	// newest price enters at the head, zero kept out of the divisors
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			prices_q[0] <= (price == '0) ? PRICE_W'(1) : price;
			for (int k = 1; k < DEPTH; k++) begin
				prices_q[k] <= prices_q[k-1];
			end
		end
	end

	// working copy walks toward the head one pair per term
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= prices_q;
		end else if (cmd.advance) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				work_q[k] <= work_q[k+1];
			end
		end
	end

	// saturating count of held prices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.push && held_q != CNT_W'(DEPTH)) begin
			held_q <= held_q + CNT_W'(1);
		end
	end

	assign cur  = work_q[0];
	assign prev = work_q[1];
	assign held = held_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module rsi_div #(
	parameter int NUM_W = 82,
	parameter int DEN_W = 59,
	parameter int QUO_W = 55
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsi_pkg::div_cmd_t   cmd,
	input  logic [NUM_W-1:0]    num,
	input  logic [DEN_W-1:0]    den,
	output rsi_pkg::div_stat_t  stat,
	output logic [QUO_W-1:0]    quo
);
	import rsi_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [CNT_W-1:0] steps;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	// a term runs over its own bits, the final ratio over the whole numerator
	assign steps = cmd.final_pass ? CNT_W'(NUM_W) : CNT_W'(QUO_W);

	// one trial subtract per cycle
	always_comb begin
		trial    = {rem_q, num_q[NUM_W-1]};
		fits     = trial >= {1'b0, den_q};
		rem_next = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	end

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand load and shift
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire
